/* hw/rtl/bss_pkg.sv */
// Shared constants, codes and types for the Bezier segment stepper.
package bss_pkg;

   localparam int COORD_BITS = 24;
   localparam int OUT_BITS   = COORD_BITS + 1;
   localparam int MAX_STEPS  = 50;
   localparam int CNT_BITS   = 6;
   localparam int WT_BITS    = 17;
   localparam int MUL_A_BITS = COORD_BITS + 1;
   localparam int MUL_B_BITS = WT_BITS + 1;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
   localparam int REM_BITS   = PROD_BITS - 1;
   localparam int QUO_BITS   = COORD_BITS;

   localparam logic [1:0] CMD_QUAD   = 2'd0;
   localparam logic [1:0] CMD_CUBIC  = 2'd1;
   localparam logic [1:0] CMD_SETPOS = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_WEIGHT,
      ST_MAC,
      ST_DIV,
      ST_EMIT
   } state_type;

endpackage

/* hw/rtl/bss_mul.sv */
// Shared signed multiplier with a registered product.
module bss_mul
   import bss_pkg::*;
(
   input  logic                         clock,
   input  logic signed [MUL_A_BITS-1:0] op_a,
   input  logic signed [MUL_B_BITS-1:0] op_b,
   output prod_type                     prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule

/* hw/rtl/bss_divider.sv */
// Restoring divider, one quotient bit per cycle, truncates toward zero.
module bss_divider
   import bss_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  prod_type           num,
   input  logic [WT_BITS-1:0] den,
   output logic               done,
   output coord_type          quo
);

   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [REM_BITS-1:0] dsh_ff, dsh_in;
   logic [QUO_BITS-1:0] q_ff, q_in;
   logic                neg_ff, neg_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [4:0]          k_ff, k_in;
   prod_type            mag;

   always_comb begin
      mag     = num[PROD_BITS-1] ? -num : num;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      k_in    = k_ff;
      if (start) begin
         rem_in  = mag[REM_BITS-1:0];
         dsh_in  = REM_BITS'(den) << (QUO_BITS - 1);
         q_in    = '0;
         neg_in  = num[PROD_BITS-1];
         busy_in = 1'b1;
         k_in    = 5'(QUO_BITS - 1);
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[QUO_BITS-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QUO_BITS-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         k_in   = k_ff - 5'd1;
         if (k_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      k_ff   <= k_in;
   end

   assign done = done_ff;
   assign quo  = neg_ff ? coord_type'(-q_ff) : coord_type'(q_ff);

endmodule

/* hw/rtl/bezier_segment_stepper_unit.sv */
// Top level of the Bezier segment stepper: sequencer, operand registers and pen state.
// A curve item of n segments (1..50) yields n+1 delta items, the last one flagged;
// a set-position item or a rejected curve yields none. The block takes no new item
// while a curve runs. After taking a curve item it first forms the divisor, then for
// each point the weight products, then per axis a multiply-accumulate on one shared
// 25x18 multiplier and a division on one shared divider (24 restoring steps, then the
// registered quotient), x then y, and last the delta item, which waits while a result
// is still held on the result side.
module bezier_segment_stepper_unit
   import bss_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_cmd,
   input  coord_type                  req_ctrl1_x,
   input  coord_type                  req_ctrl1_y,
   input  coord_type                  req_ctrl2_x,
   input  coord_type                  req_ctrl2_y,
   input  coord_type                  req_end_x,
   input  coord_type                  req_end_y,
   input  logic [7:0]                 req_steps,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [OUT_BITS-1:0] rsp_step_dx,
   output logic signed [OUT_BITS-1:0] rsp_step_dy,
   output logic                       rsp_last_step
);

   state_type state_ff, state_in;
   logic [2:0] st_ff, st_in;
   logic axis_ff, axis_in;
   logic cubic_ff, cubic_in;
   logic [CNT_BITS-1:0] n_ff, n_in, i_ff, i_in;
   coord_type c1x_ff, c1x_in, c1y_ff, c1y_in, c2x_ff, c2x_in, c2y_ff, c2y_in;
   coord_type ex_ff, ex_in, ey_ff, ey_in, sx_ff, sx_in, sy_ff, sy_in;
   coord_type pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   coord_type px_ff, px_in, py_ff, py_in;
   logic [WT_BITS-1:0] d_ff, d_in;
   logic [11:0] aa_ff, aa_in, ii_ff, ii_in;
   logic [WT_BITS-1:0] w_ff [4], w_in [4];
   prod_type acc_ff, acc_in;
   logic rsp_valid_ff, rsp_valid_in, last_ff, last_in;
   logic signed [OUT_BITS-1:0] dx_ff, dx_in, dy_ff, dy_in;

   logic signed [MUL_A_BITS-1:0] mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   prod_type prod;
   logic [WT_BITS-1:0] p17;
   logic [CNT_BITS-1:0] a_w;
   logic div_start, div_done;
   coord_type quo;
   coord_type term_c [4];
   logic [2:0] n_terms;
   logic emit_go;

   bss_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   bss_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (acc_in),
      .den   (d_ff),
      .done  (div_done),
      .quo   (quo)
   );

   assign p17     = prod[WT_BITS-1:0];
   assign a_w     = n_ff - i_ff;
   assign n_terms = cubic_ff ? 3'd4 : 3'd3;
   assign emit_go = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      term_c[0] = axis_ff ? sy_ff  : sx_ff;
      term_c[1] = axis_ff ? c1y_ff : c1x_ff;
      term_c[2] = cubic_ff ? (axis_ff ? c2y_ff : c2x_ff) : (axis_ff ? ey_ff : ex_ff);
      term_c[3] = axis_ff ? ey_ff  : ex_ff;
   end

   always_comb begin
      state_in = state_ff;
      st_in = st_ff;
      axis_in = axis_ff;
      cubic_in = cubic_ff;
      n_in = n_ff;
      i_in = i_ff;
      c1x_in = c1x_ff; c1y_in = c1y_ff; c2x_in = c2x_ff; c2y_in = c2y_ff;
      ex_in = ex_ff; ey_in = ey_ff; sx_in = sx_ff; sy_in = sy_ff;
      pen_x_in = pen_x_ff; pen_y_in = pen_y_ff;
      px_in = px_ff; py_in = py_ff;
      d_in = d_ff; aa_in = aa_ff; ii_in = ii_ff;
      w_in = w_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      last_in = last_ff; dx_in = dx_ff; dy_in = dy_ff;
      mul_a = '0;
      mul_b = '0;
      div_start = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_SETPOS) begin
                  pen_x_in = req_end_x;
                  pen_y_in = req_end_y;
               end else if ((req_cmd == CMD_QUAD || req_cmd == CMD_CUBIC) &&
                            req_steps >= 8'd1 && req_steps <= 8'(MAX_STEPS)) begin
                  cubic_in = (req_cmd == CMD_CUBIC);
                  n_in = req_steps[CNT_BITS-1:0];
                  i_in = '0;
                  c1x_in = req_ctrl1_x; c1y_in = req_ctrl1_y;
                  c2x_in = req_ctrl2_x; c2y_in = req_ctrl2_y;
                  ex_in = req_end_x; ey_in = req_end_y;
                  sx_in = pen_x_ff; sy_in = pen_y_ff;
                  st_in = '0;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            // divisor n^2, then n^3 for a cubic
            st_in = st_ff + 3'd1;
            case (st_ff)
               3'd0: begin
                  mul_a = MUL_A_BITS'(n_ff);
                  mul_b = MUL_B_BITS'(n_ff);
               end
               3'd1: begin
                  d_in = p17;
                  if (!cubic_ff) begin
                     st_in = '0;
                     state_in = ST_WEIGHT;
                  end
               end
               3'd2: begin
                  mul_a = MUL_A_BITS'(n_ff);
                  mul_b = MUL_B_BITS'(d_ff);
               end
               default: begin
                  d_in = p17;
                  st_in = '0;
                  state_in = ST_WEIGHT;
               end
            endcase
         end
         ST_WEIGHT: begin
            // issue one product a cycle, take the previous one
            st_in = st_ff + 3'd1;
            if (!cubic_ff) begin
               case (st_ff)
                  3'd0: begin
                     mul_a = MUL_A_BITS'(a_w); mul_b = MUL_B_BITS'(a_w);
                  end
                  3'd1: begin
                     w_in[0] = p17;
                     mul_a = MUL_A_BITS'(a_w); mul_b = MUL_B_BITS'(i_ff);
                  end
                  3'd2: begin
                     w_in[1] = p17 << 1;
                     mul_a = MUL_A_BITS'(i_ff); mul_b = MUL_B_BITS'(i_ff);
                  end
                  default: begin
                     w_in[2] = p17;
                     w_in[3] = '0;
                     st_in = '0; axis_in = 1'b0; acc_in = '0;
                     state_in = ST_MAC;
                  end
               endcase
            end else begin
               case (st_ff)
                  3'd0: begin
                     mul_a = MUL_A_BITS'(a_w); mul_b = MUL_B_BITS'(a_w);
                  end
                  3'd1: begin
                     aa_in = prod[11:0];
                     mul_a = MUL_A_BITS'(i_ff); mul_b = MUL_B_BITS'(i_ff);
                  end
                  3'd2: begin
                     ii_in = prod[11:0];
                     mul_a = MUL_A_BITS'(aa_ff); mul_b = MUL_B_BITS'(a_w);
                  end
                  3'd3: begin
                     w_in[0] = p17;
                     mul_a = MUL_A_BITS'(aa_ff); mul_b = MUL_B_BITS'(i_ff);
                  end
                  3'd4: begin
                     w_in[1] = p17 + (p17 << 1);
                     mul_a = MUL_A_BITS'(ii_ff); mul_b = MUL_B_BITS'(a_w);
                  end
                  3'd5: begin
                     w_in[2] = p17 + (p17 << 1);
                     mul_a = MUL_A_BITS'(ii_ff); mul_b = MUL_B_BITS'(i_ff);
                  end
                  default: begin
                     w_in[3] = p17;
                     st_in = '0; axis_in = 1'b0; acc_in = '0;
                     state_in = ST_MAC;
                  end
               endcase
            end
         end
         ST_MAC: begin
            st_in = st_ff + 3'd1;
            if (st_ff != '0) begin
               acc_in = acc_ff + prod;
            end
            if (st_ff < n_terms) begin
               mul_a = MUL_A_BITS'(term_c[st_ff[1:0]]);
               mul_b = MUL_B_BITS'(w_ff[st_ff[1:0]]);
            end else begin
               div_start = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (!axis_ff) begin
                  px_in = quo;
                  axis_in = 1'b1;
                  st_in = '0;
                  acc_in = '0;
                  state_in = ST_MAC;
               end else begin
                  py_in = quo;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               dx_in = OUT_BITS'(px_ff) - OUT_BITS'(pen_x_ff);
               dy_in = OUT_BITS'(py_ff) - OUT_BITS'(pen_y_ff);
               last_in = (i_ff == n_ff);
               pen_x_in = px_ff;
               pen_y_in = py_ff;
               if (i_ff == n_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
                  st_in = '0;
                  state_in = ST_WEIGHT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         st_ff <= '0;
         axis_ff <= 1'b0;
         i_ff <= '0;
         n_ff <= '0;
         pen_x_ff <= '0;
         pen_y_ff <= '0;
         sx_ff <= '0;
         sy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         st_ff <= st_in;
         axis_ff <= axis_in;
         i_ff <= i_in;
         n_ff <= n_in;
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cubic_ff <= cubic_in;
      c1x_ff <= c1x_in; c1y_ff <= c1y_in; c2x_ff <= c2x_in; c2y_ff <= c2y_in;
      ex_ff <= ex_in; ey_ff <= ey_in;
      px_ff <= px_in; py_ff <= py_in;
      d_ff <= d_in; aa_ff <= aa_in; ii_ff <= ii_in;
      w_ff <= w_in;
      acc_ff <= acc_in;
      dx_ff <= dx_in; dy_ff <= dy_in; last_ff <= last_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_step_dx   = dx_ff;
   assign rsp_step_dy   = dy_ff;
   assign rsp_last_step = last_ff;

`ifndef SYNTH
   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> i_ff <= n_ff)
      else $error("point index beyond step count");
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      emit_go && i_ff == n_ff |=> state_ff == ST_IDLE && rsp_valid && rsp_last_step)
      else $error("final point did not end the curve");
`endif

endmodule
